[design/tdpt_pkg.sv]
// Shared types and constants of the trial-division prime test unit.
`default_nettype none

package tdpt_pkg;

	// Primes that the table holds after reset
	localparam int SEED_COUNT = 5;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_DONE,
		ST_RESP
	} tdpt_state_t;

	// Seed prime at table index i (valid for i below SEED_COUNT)
	function automatic logic [7:0] seed_prime(input logic [2:0] i);
		logic [7:0] p;
		unique case (i)
			3'd0: p = 8'd2;
			3'd1: p = 8'd3;
			3'd2: p = 8'd5;
			3'd3: p = 8'd7;
			3'd4: p = 8'd11;
			default: p = 8'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

[design/tdpt_req_if.sv]
// Request channel of the prime test unit: mode and candidate.
`default_nettype none

interface tdpt_req_if #(
	parameter int NUM_BITS = 20
);
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [NUM_BITS-1:0] candidate;

	modport source (output valid, output req_type, output candidate, input ready);
	modport sink (input valid, input req_type, input candidate, output ready);
endinterface

`default_nettype wire

[design/tdpt_rsp_if.sv]
// Result channel of the prime test unit: verdict and table flags.
`default_nettype none

interface tdpt_rsp_if;
	logic valid;
	logic ready;
	logic is_prime;
	logic table_exhausted;
	logic appended;

	modport source (output valid, output is_prime, output table_exhausted,
		output appended, input ready);
	modport sink (input valid, input is_prime, input table_exhausted,
		input appended, output ready);
endinterface

`default_nettype wire

[design/tdpt_rem.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module tdpt_rem #(
	parameter int W = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      rem
);
	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     dvd_q;
	logic [W-1:0]     dvs_q;
	logic [W-1:0]     rem_q;
	logic [W:0]       trial;
	logic [W:0]       diff;

	// Shift in the next dividend bit and try one subtract
	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= trial[W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[design/trial_division_prime_test_unit.sv]
// Top level of the trial-division prime test unit.
// Takes one candidate per request and tests it against an ascending table of
// primes (seeded with 2, 3, 5, 7, 11). Each tried prime takes a table read,
// a load, NUM_BITS steps of the bit-serial remainder unit, which sets the
// pace, and a check of the remainder. Candidates 1, 2, 3 and 5 are decided
// without division. The unit holds one request at a time and is not ready
// until the result has been taken. With req_type set, a prime result is
// appended to the table while it has room; the host must feed such
// candidates in ascending order. No clearing pass is needed after reset.
`default_nettype none

module trial_division_prime_test_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int NUM_BITS    = 20
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tdpt_req_if.sink   req,
	tdpt_rsp_if.source rsp
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	tdpt_pkg::tdpt_state_t state_q, state_n;

	logic [NUM_BITS-1:0]   cand_q;
	logic                  mode_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         count_q;
	logic [NUM_BITS-1:0]   p_q;
	logic [NUM_BITS-1:0]   rd_q;
	logic [2*NUM_BITS-1:0] sq_q;
	logic                  prime_q;
	logic                  exh_q;
	logic                  app_q;

	logic [NUM_BITS-1:0]   mem [TABLE_DEPTH];

	logic                  accept;
	logic                  special;
	logic                  tbl_end;
	logic                  mem_re;
	logic                  div_start;
	logic                  divides;
	logic                  bound_hit;
	logic                  found_div;
	logic                  next_idx;
	logic                  finish;
	logic                  do_append;
	logic                  div_done;
	logic [NUM_BITS-1:0]   rem;
	logic [NUM_BITS-1:0]   p_sel;
	logic [NUM_BITS-1:0]   pm;

	// Candidates decided without division
	assign special = (req.candidate == NUM_BITS'(1)) || (req.candidate == NUM_BITS'(2)) ||
		(req.candidate == NUM_BITS'(3)) || (req.candidate == NUM_BITS'(5));

	assign tbl_end   = (idx_q >= count_q);
	assign divides   = (p_q != '0) && (rem == '0);
	assign bound_hit = (sq_q >= {NUM_BITS'(0), cand_q});
	assign do_append = mode_q && prime_q && (count_q < CW'(TABLE_DEPTH));

	// Prime under test: seeds come from the constant table
	assign p_sel = (idx_q < CW'(tdpt_pkg::SEED_COUNT)) ?
		NUM_BITS'(tdpt_pkg::seed_prime(idx_q[2:0])) : rd_q;
	assign pm = (p_q != '0) ? p_q - NUM_BITS'(1) : '0;

	// Shared remainder unit
	tdpt_rem #(
		.W(NUM_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_q),
		.divisor  (p_sel),
		.done     (div_done),
		.rem      (rem)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and control
	always_comb begin
		state_n   = state_q;
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		accept    = 1'b0;
		mem_re    = 1'b0;
		div_start = 1'b0;
		found_div = 1'b0;
		next_idx  = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			tdpt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					accept  = 1'b1;
					state_n = special ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_FETCH;
				end
			end
			tdpt_pkg::ST_FETCH: begin
				if (tbl_end) begin
					state_n = tdpt_pkg::ST_DONE;
				end else begin
					mem_re  = 1'b1;
					state_n = tdpt_pkg::ST_LOAD;
				end
			end
			tdpt_pkg::ST_LOAD: begin
				div_start = 1'b1;
				state_n   = tdpt_pkg::ST_DIV;
			end
			tdpt_pkg::ST_DIV: begin
				if (div_done) begin
					if (divides) begin
						found_div = 1'b1;
						state_n   = tdpt_pkg::ST_DONE;
					end else if (bound_hit) begin
						state_n = tdpt_pkg::ST_DONE;
					end else begin
						next_idx = 1'b1;
						state_n  = tdpt_pkg::ST_FETCH;
					end
				end
			end
			tdpt_pkg::ST_DONE: begin
				finish  = 1'b1;
				state_n = tdpt_pkg::ST_RESP;
			end
			tdpt_pkg::ST_RESP: begin
				rsp.valid = 1'b1;
				if (rsp.ready) begin
					state_n = tdpt_pkg::ST_IDLE;
				end
			end
			default: state_n = tdpt_pkg::ST_IDLE;
		endcase
	end

	// Table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(tdpt_pkg::SEED_COUNT);
		end else if (finish && do_append) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Prime table: written on append, read one entry per tried prime
	always_ff @(posedge clk) begin
		if (finish && do_append) begin
			mem[count_q[IW-1:0]] <= cand_q;
		end
		if (mem_re) begin
			rd_q <= mem[idx_q[IW-1:0]];
		end
	end

	// Request datapath and result flags
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q  <= req.candidate;
			mode_q  <= req.req_type;
			idx_q   <= '0;
			prime_q <= (req.candidate != NUM_BITS'(1));
			exh_q   <= 1'b0;
		end
		if (state_q == tdpt_pkg::ST_FETCH && tbl_end) begin
			exh_q <= 1'b1;
		end
		if (div_start) begin
			p_q <= p_sel;
		end
		if (state_q == tdpt_pkg::ST_DIV) begin
			sq_q <= {NUM_BITS'(0), pm} * {NUM_BITS'(0), pm};
		end
		if (found_div) begin
			prime_q <= 1'b0;
		end
		if (next_idx) begin
			idx_q <= idx_q + CW'(1);
		end
		if (finish) begin
			app_q <= do_append;
		end
	end

	assign rsp.is_prime        = prime_q;
	assign rsp.table_exhausted = exh_q;
	assign rsp.appended        = app_q;

endmodule

`default_nettype wire

[tb/sv/trial_division_prime_test_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the trial-division prime test unit: directed and random requests.

module trial_division_prime_test_unit_tb;

	localparam int TABLE_DEPTH    = 256;
	localparam int NUM_BITS       = 20;
	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 20000;

	// Request modes
	localparam logic REQ_TEST   = 1'b0;
	localparam logic REQ_APPEND = 1'b1;

	typedef struct packed {
		logic is_prime;
		logic table_exhausted;
		logic appended;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	tdpt_req_if #(.NUM_BITS(NUM_BITS)) req_ch ();
	tdpt_rsp_if rsp_ch ();

	trial_division_prime_test_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.NUM_BITS(NUM_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the prime table and its fill count
	logic [NUM_BITS-1:0] prime_shadow [TABLE_DEPTH];
	int                  shadow_count;

	verdict_t pending_verdicts [$];
	int       mismatch_count = 0;
	int       quiet_cycles   = 0;
	bit       steady         = 1'b0;

	// Verdict of a candidate against the current shadow table, no side effects
	function automatic verdict_t trial_verdict(input logic [NUM_BITS-1:0] cand);
		logic [63:0] c;
		logic [63:0] p;
		logic [63:0] pm;
		verdict_t    v;
		v = '0;
		c = 64'(cand);
		if (cand == 1) return v;
		if (cand == 2 || cand == 3 || cand == 5) begin
			v.is_prime = 1'b1;
			return v;
		end
		for (int idx = 0; idx < shadow_count && idx < TABLE_DEPTH; idx++) begin
			p = 64'(prime_shadow[idx]);
			// a zero entry never divides
			if (p != 0 && (c % p) == 0) return v;
			pm = (p != 0) ? p - 1 : 64'd0;
			if (pm * pm >= c) begin
				v.is_prime = 1'b1;
				return v;
			end
		end
		// ran off the end of the table
		v.is_prime = 1'b1;
		v.table_exhausted = 1'b1;
		return v;
	endfunction

	// Plain primality, used only to choose candidates for the table
	function automatic bit is_true_prime(input int n);
		if (n < 2) return 1'b0;
		for (int d = 2; d * d <= n; d++)
			if (n % d == 0) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int next_true_prime(input int n);
		int k;
		k = n;
		while (!is_true_prime(k)) k++;
		return k;
	endfunction

	function automatic int draw_idle();
		return steady ? 0 : $urandom_range(15, 0);
	endfunction

	// Update the shadow table for an accepted request and queue its verdict
	task automatic record_request(input logic mode, input logic [NUM_BITS-1:0] cand);
		verdict_t v;
		v = trial_verdict(cand);
		if (mode == REQ_APPEND && v.is_prime && shadow_count < TABLE_DEPTH) begin
			prime_shadow[shadow_count] = cand;
			shadow_count++;
			v.appended = 1'b1;
		end
		pending_verdicts.push_back(v);
	endtask

	// Drive one request after a random gap and wait for it to be taken
	task automatic send_candidate(input logic mode, input logic [NUM_BITS-1:0] cand);
		int gap;
		gap = draw_idle();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= mode;
		req_ch.candidate <= cand;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		record_request(mode, cand);
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic wait_for_verdicts();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic expv, input logic actv);
		if (actv !== expv) begin
			$display("%0t ns: %s mismatch: expected %0b, actual %0b", $time, name, expv, actv);
			mismatch_count++;
		end
	endtask

	// Seed table only: special candidates, extremes, early exhaustion
	task automatic test_seed_verdicts();
		logic [NUM_BITS-1:0] probes [19] = '{
			20'd0, 20'd1, 20'd2, 20'd3, 20'd5, 20'd4, 20'd7, 20'd11, 20'd9, 20'd25,
			20'd49, 20'd121, 20'd13, 20'd143, 20'd169, 20'hFFFFF, 20'd1048573,
			20'h55555, 20'hAAAAA
		};
		steady = 1'b0;
		foreach (probes[i]) send_candidate(REQ_TEST, probes[i]);
	endtask

	// An exhausted prime is still stored; composites are not
	task automatic test_exhausted_append();
		send_candidate(REQ_APPEND, 20'd127);
		send_candidate(REQ_APPEND, 20'd129);
		// 13 is missing from the table, so 169 now passes as prime
		send_candidate(REQ_TEST, 20'd169);
	endtask

	// Grow the table with ascending primes, mixed with random test-only requests
	task automatic test_table_build();
		int       cursor;
		int       cand;
		int       r;
		logic     mode;
		verdict_t v;
		cursor = 127;
		while (shadow_count < TABLE_DEPTH - 6) begin
			if ($urandom_range(31, 0) == 0) steady = !steady;
			r = $urandom_range(99, 0);
			if (r < 20) begin
				// mostly small candidates so the walk stays short
				if (r < 8) cand = int'($urandom() & 32'hFFFFF);
				else cand = $urandom_range(5000, 0);
				send_candidate(REQ_TEST, NUM_BITS'(cand));
			end else begin
				if (r < 30) begin
					cand = cursor + $urandom_range(6, 1);
				end else begin
					cand = next_true_prime(cursor + 1);
					if ($urandom_range(9, 0) == 0) cand = next_true_prime(cand + 1);
				end
				// keep false primes out of the table where holes would let them in
				mode = REQ_APPEND;
				v = trial_verdict(NUM_BITS'(cand));
				if (!is_true_prime(cand) && v.is_prime) mode = REQ_TEST;
				send_candidate(mode, NUM_BITS'(cand));
				cursor = cand;
			end
		end
	endtask

	// Small primes appended late, then fill the table and append past its end
	task automatic test_table_full();
		int cursor;
		steady = 1'b1;
		send_candidate(REQ_APPEND, 20'd3);
		send_candidate(REQ_APPEND, 20'd5);
		cursor = int'(prime_shadow[shadow_count - 3]);
		repeat (7) begin
			cursor = next_true_prime(cursor + 1);
			send_candidate(REQ_APPEND, NUM_BITS'(cursor));
		end
		send_candidate(REQ_APPEND, 20'd2);
		steady = 1'b0;
		send_candidate(REQ_TEST, 20'd1048573);
		send_candidate(REQ_TEST, 20'd999983);
		send_candidate(REQ_TEST, 20'hFFFFF);
		send_candidate(REQ_TEST, 20'd0);
		send_candidate(REQ_TEST, 20'd1);
	endtask

	// Result side: random stall before each result
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_idle();
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Compare each result with the oldest expected verdict
	always @(posedge clk) begin
		verdict_t expv;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t ns: result with no request pending: expected none, actual %0b%0b%0b",
					$time, rsp_ch.is_prime, rsp_ch.table_exhausted, rsp_ch.appended);
				mismatch_count++;
			end else begin
				expv = pending_verdicts.pop_front();
				check_field("is_prime", expv.is_prime, rsp_ch.is_prime);
				check_field("table_exhausted", expv.table_exhausted, rsp_ch.table_exhausted);
				check_field("appended", expv.appended, rsp_ch.appended);
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_TEST;
		req_ch.candidate = '0;
		// table contents after reset
		foreach (prime_shadow[i]) prime_shadow[i] = '0;
		prime_shadow[0] = 20'd2;
		prime_shadow[1] = 20'd3;
		prime_shadow[2] = 20'd5;
		prime_shadow[3] = 20'd7;
		prime_shadow[4] = 20'd11;
		shadow_count = tdpt_pkg::SEED_COUNT;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		test_seed_verdicts();
		wait_for_verdicts();
		test_exhausted_append();
		wait_for_verdicts();
		test_table_build();
		wait_for_verdicts();
		test_table_full();
		wait_for_verdicts();
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
design/tdpt_pkg.sv
design/tdpt_req_if.sv
design/tdpt_rsp_if.sv
design/tdpt_rem.sv
design/trial_division_prime_test_unit.sv
tb/sv/trial_division_prime_test_unit_tb.sv
